// ===== design/next_fit_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Next-fit block allocator assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define NFBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define NFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NFBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define NFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// Next-fit block allocator package
// Shared widths, codes, sequencer states and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

    localparam int HEAP_WORDS_DEF = 1024;

    localparam int START_W  = 13;
    localparam int END_W    = 14;
    localparam int REQ_W    = 14;
    localparam int ADDR_W   = 13;
    localparam int STATUS_W = 2;
    localparam int NEED_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [END_W-1:0] HEAP_END_RST = 14'd8192;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_END   = 1'b1
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   user_address;
    } t_result;

    typedef enum logic [1:0] {
        ALU_SUB   = 2'd0,
        ALU_SUBM1 = 2'd1,
        ALU_ADD1  = 2'd2
    } t_alu_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LAYOUT,
        S_LAY_W2,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_END,
        S_FIT_SZ,
        S_FIT_CMP,
        S_TAKE,
        S_SPLIT_NW,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_ADV,
        S_FREE_RED,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_NRD,
        S_FREE_NCHK
    } t_state;

endpackage

`default_nettype wire

// ===== design/nfba_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// Header table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_hdr_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/nfba_alu.sv =====
// ----------------------------------------------------------------------------
// Shared adder unit
// Add or subtract with carry out, used for block sizes and split points.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_alu #(
    parameter int AW = 13
) (
    input  wire nfba_pkg::t_alu_op i_op,
    input  wire logic [AW-1:0]     i_a,
    input  wire logic [AW-1:0]     i_b,
    output logic      [AW-1:0]     o_res,
    output logic                   o_carry
);

    import nfba_pkg::*;

    logic [AW-1:0] b_opnd;
    logic          cin;
    logic [AW:0]   sum;

    always_comb begin
        unique case (i_op)
            ALU_SUB: begin
                b_opnd = ~i_b;
                cin    = 1'b1;
            end
            ALU_SUBM1: begin
                b_opnd = ~i_b;
                cin    = 1'b0;
            end
            ALU_ADD1: begin
                b_opnd = i_b;
                cin    = 1'b1;
            end
            default: begin
                b_opnd = i_b;
                cin    = 1'b0;
            end
        endcase
    end

    // For the subtracting operations a carry out means no borrow.
    assign sum     = {1'b0, i_a} + {1'b0, b_opnd} + {{AW{1'b0}}, cin};
    assign o_res   = sum[AW-1:0];
    assign o_carry = sum[AW];

endmodule

`default_nettype wire

// ===== design/nfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the header list one memory access at a time, merges free runs and
// takes or splits the first block that fits; also lays out the heap and handles frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_ctrl #(
    parameter int HEAP_WORDS = nfba_pkg::HEAP_WORDS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_action,
    input  wire logic [nfba_pkg::REQ_W-1:0]    i_request_bytes,
    input  wire logic [nfba_pkg::ADDR_W-1:0]   i_block_address,
    input  wire logic [nfba_pkg::START_W-1:0]  i_heap_start,
    input  wire logic [nfba_pkg::END_W-1:0]    i_heap_end,
    output logic                               o_busy,
    output logic                               o_valid,
    output nfba_pkg::t_result                  o_result
);

    import nfba_pkg::*;

    localparam int IDX_W = $clog2(HEAP_WORDS);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (IDX_W + 4 > 15) ? IDX_W + 4 : 15;
    localparam int AW    = ((IDX_W > NEED_W) ? IDX_W : NEED_W) + 1;
    localparam int DW    = IDX_W + 1;

    localparam logic [CNT_W-1:0] HW_CNT   = CNT_W'(HEAP_WORDS);
    localparam logic [CNT_W-1:0] HW_LAST  = CNT_W'(HEAP_WORDS - 1);
    localparam logic [CW-1:0]    HW_WORDS = CW'(HEAP_WORDS);
    localparam logic [CW-1:0]    HW_BYTES = CW'(HEAP_WORDS * 8);

    t_state n_state;
    t_state r_state;

    logic             r_valid;
    t_result          r_result;
    logic             r_init;
    logic [IDX_W-1:0] r_rover;
    logic [CNT_W-1:0] r_steps;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_t;
    logic [IDX_W-1:0] r_n;
    logic [CNT_W-1:0] r_k;
    logic [NEED_W-1:0] r_need;
    logic [AW-1:0]    r_size;
    logic [CW-1:0]    r_red;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [DW-1:0]    mem_rdata;

    t_alu_op          alu_op;
    logic [AW-1:0]    alu_a;
    logic [AW-1:0]    alu_b;
    logic [AW-1:0]    alu_res;
    logic             alu_carry;

    logic             fin;
    t_result          fin_res;
    logic             rov_we;
    logic [IDX_W-1:0] rov_val;
    logic             init_set;

    logic             rd_free;
    logic [IDX_W-1:0] rd_next;

    logic [REQ_W:0]   req_round;
    logic [NEED_W-1:0] req_need;
    logic [9:0]       free_word;
    logic [CW-1:0]    lay_start;
    logic [CW-1:0]    lay_end_raw;
    logic [CW-1:0]    lay_end;
    logic [CW-1:0]    lay_last_full;
    logic             lay_fail;
    logic [IDX_W-1:0] lay_first;
    logic [IDX_W-1:0] lay_last;
    logic [CW-1:0]    uaddr_full;
    logic             adv_stop;
    logic             fit_small;

    nfba_hdr_mem #(
        .DEPTH (HEAP_WORDS),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    nfba_alu #(
        .AW (AW)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    assign rd_free = mem_rdata[0];
    assign rd_next = mem_rdata[IDX_W:1];

    // Words needed: the request rounded up to whole 8-byte words.
    assign req_round = {1'b0, i_request_bytes} + (REQ_W + 1)'(7);
    assign req_need  = req_round[REQ_W:3];

    // Header word of a freed user address, before reduction into the table.
    assign free_word = i_block_address[ADDR_W-1:3] - 10'd1;

    assign lay_start     = (CW'(i_heap_start) + CW'(7)) & ~CW'(7);
    assign lay_end_raw   = CW'(i_heap_end) & ~CW'(7);
    assign lay_end       = (lay_end_raw > HW_BYTES) ? HW_BYTES : lay_end_raw;
    assign lay_fail      = (lay_start + CW'(24)) > lay_end;
    assign lay_first     = lay_start[IDX_W+2:3];
    assign lay_last_full = (lay_end >> 3) - CW'(1);
    assign lay_last      = lay_last_full[IDX_W-1:0];

    assign uaddr_full = (CW'(r_cur) + CW'(1)) << 3;
    assign adv_stop   = (r_n == r_start) || (r_steps == HW_LAST);
    assign fit_small  = alu_res < AW'(2);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_steps == HW_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_FREE) begin
                        n_state = r_init ? S_FREE_RED : S_IDLE;
                    end else begin
                        n_state = r_init ? S_SRCH_RD : S_LAYOUT;
                    end
                end
            end
            S_LAYOUT:   n_state = lay_fail ? S_IDLE : S_LAY_W2;
            S_LAY_W2:   n_state = S_SRCH_RD;
            S_SRCH_RD:  n_state = S_SRCH_CHK;
            S_SRCH_CHK: n_state = rd_free ? S_MRG_RD : S_ADV;
            S_MRG_RD:   n_state = (r_k == HW_CNT) ? S_MRG_END : S_MRG_CHK;
            S_MRG_CHK:  n_state = rd_free ? S_MRG_RD : S_MRG_END;
            S_MRG_END:  n_state = S_FIT_SZ;
            S_FIT_SZ:   n_state = alu_carry ? S_FIT_CMP : S_ADV;
            S_FIT_CMP: begin
                priority if (!alu_carry) begin
                    n_state = S_ADV;
                end else if (fit_small) begin
                    n_state = S_TAKE;
                end else begin
                    n_state = S_SPLIT_NW;
                end
            end
            S_TAKE:      n_state = S_IDLE;
            S_SPLIT_NW:  n_state = S_SPLIT_W1;
            S_SPLIT_W1:  n_state = S_SPLIT_W2;
            S_SPLIT_W2:  n_state = S_IDLE;
            S_ADV:       n_state = adv_stop ? S_IDLE : S_SRCH_RD;
            S_FREE_RED:  n_state = (r_red >= HW_WORDS) ? S_FREE_RED : S_FREE_RD;
            S_FREE_RD:   n_state = S_FREE_CHK;
            S_FREE_CHK:  n_state = rd_free ? S_IDLE : S_FREE_NRD;
            S_FREE_NRD:  n_state = S_FREE_NCHK;
            S_FREE_NCHK: n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Memory, adder and result controls for the current state.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = '0;
        mem_raddr = r_cur;
        alu_op    = ALU_SUB;
        alu_a     = AW'(r_size);
        alu_b     = AW'(r_need);
        fin       = 1'b0;
        fin_res   = '{status: ST_DONE, user_address: '0};
        rov_we    = 1'b0;
        rov_val   = r_n;
        init_set  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_steps[IDX_W-1:0];
            end
            S_IDLE: begin
                if (i_start && (i_action == ACT_FREE) && !r_init) begin
                    fin     = 1'b1;
                    fin_res = '{status: ST_NO_FIT, user_address: '0};
                end
            end
            S_LAYOUT: begin
                if (lay_fail) begin
                    fin     = 1'b1;
                    fin_res = '{status: ST_NO_FIT, user_address: '0};
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = lay_first;
                    mem_wdata = {lay_last, 1'b1};
                end
            end
            S_LAY_W2: begin
                mem_we    = 1'b1;
                mem_waddr = r_t;
                mem_wdata = {r_cur, 1'b0};
                rov_we    = 1'b1;
                rov_val   = r_cur;
                init_set  = 1'b1;
            end
            S_SRCH_RD:  mem_raddr = r_cur;
            S_SRCH_CHK: mem_raddr = r_cur;
            S_MRG_RD:   mem_raddr = r_t;
            S_MRG_CHK:  mem_raddr = r_t;
            S_MRG_END: begin
                if (r_t != r_cur) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {r_t, 1'b1};
                end
            end
            S_FIT_SZ: begin
                // Size of the block in words is next minus this minus one.
                alu_op = ALU_SUBM1;
                alu_a  = AW'(r_n);
                alu_b  = AW'(r_cur);
            end
            S_FIT_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = r_size;
                alu_b  = AW'(r_need);
            end
            S_TAKE: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {r_n, 1'b0};
                rov_we    = 1'b1;
                rov_val   = r_n;
                fin       = 1'b1;
                fin_res   = '{status: ST_DONE, user_address: uaddr_full[ADDR_W-1:0]};
            end
            S_SPLIT_NW: begin
                alu_op = ALU_ADD1;
                alu_a  = AW'(r_cur);
                alu_b  = AW'(r_need);
            end
            S_SPLIT_W1: begin
                mem_we    = 1'b1;
                mem_waddr = r_t;
                mem_wdata = {r_n, 1'b1};
            end
            S_SPLIT_W2: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {r_t, 1'b0};
                rov_we    = 1'b1;
                rov_val   = r_t;
                fin       = 1'b1;
                fin_res   = '{status: ST_DONE, user_address: uaddr_full[ADDR_W-1:0]};
            end
            S_ADV: begin
                if (adv_stop) begin
                    rov_we  = 1'b1;
                    rov_val = r_n;
                    fin     = 1'b1;
                    fin_res = '{status: ST_NO_FIT, user_address: '0};
                end
            end
            S_FREE_RED:  mem_raddr = r_cur;
            S_FREE_RD:   mem_raddr = r_cur;
            S_FREE_CHK: begin
                mem_raddr = r_cur;
                if (rd_free) begin
                    fin     = 1'b1;
                    fin_res = '{status: ST_IGNORED, user_address: '0};
                end
            end
            S_FREE_NRD:  mem_raddr = r_n;
            S_FREE_NCHK: begin
                // A free successor is absorbed by linking past it.
                mem_raddr = r_n;
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = rd_free ? {rd_next, 1'b1} : {r_n, 1'b1};
                fin       = 1'b1;
                fin_res   = '{status: ST_DONE, user_address: '0};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_init  <= 1'b0;
            r_rover <= '0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= fin;
            if (init_set) begin
                r_init <= 1'b1;
            end
            if (rov_we) begin
                r_rover <= rov_val;
            end
            if ((r_state == S_CLEAR) || (r_state == S_ADV)) begin
                r_steps <= r_steps + CNT_W'(1);
            end else if (r_state == S_IDLE) begin
                r_steps <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_result <= fin_res;
        end
        unique case (r_state)
            S_IDLE: begin
                r_need  <= req_need;
                r_cur   <= r_rover;
                r_start <= r_rover;
                r_red   <= CW'(free_word);
            end
            S_LAYOUT: begin
                r_cur   <= lay_first;
                r_start <= lay_first;
                r_t     <= lay_last;
            end
            S_SRCH_CHK: begin
                r_n <= rd_next;
                r_t <= rd_next;
                r_k <= CNT_W'(1);
            end
            S_MRG_CHK: begin
                if (rd_free) begin
                    r_t <= rd_next;
                    r_k <= r_k + CNT_W'(1);
                end
            end
            S_MRG_END: begin
                if (r_t != r_cur) begin
                    r_n <= r_t;
                end
            end
            S_FIT_SZ:   r_size <= alu_res;
            S_SPLIT_NW: r_t    <= alu_res[IDX_W-1:0];
            S_ADV:      r_cur  <= r_n;
            S_FREE_RED: begin
                if (r_red >= HW_WORDS) begin
                    r_red <= r_red - HW_WORDS;
                end else begin
                    r_cur <= r_red[IDX_W-1:0];
                end
            end
            S_FREE_CHK: r_n <= rd_next;
            default: begin
                r_size <= r_size;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== design/next_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Next-fit block allocator
// Heap allocator over 8-byte words with a circular header list and a rover.
// ----------------------------------------------------------------------------
// After reset the block sweeps its header table clear, one entry a cycle, and
// holds busy high while it does so. Configuration writes are taken at any
// time, but the heap is laid out only once, from the values held when an
// allocation first finds them large enough. An item is taken when start is
// high and busy is low. Its one result appears on o_status and o_user_address
// for a single cycle with o_valid high; the receiver cannot stall it, so
// capture it then. A free before layout answers in the cycle after it is
// taken. Any other free folds its address into the table by repeated
// subtraction of HEAP_WORDS, then reads the block header and then its
// successor; a free whose header is already free is ignored after the first
// read. For each used block the search passes over, an allocation reads its
// header and moves on. A free block is read, the free blocks that follow are
// merged into its run one at a time, and it is sized against the request and
// passed over if it does not fit. A block that fits is taken whole with one
// header write, or split by working out the new header and then writing two
// headers; the result follows in the next cycle. The allocation that lays out
// the heap writes two headers before its search, or gives no fit when the heap
// is too small. The time comes from the header memory's registered read, which
// separates issuing each list step from seeing the header, and from the single
// adder shared by the size checks, so it grows with how fragmented the heap is.
// ----------------------------------------------------------------------------
`default_nettype none
`include "next_fit_block_allocator_macros.svh"

module next_fit_block_allocator #(
    parameter int HEAP_WORDS = nfba_pkg::HEAP_WORDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_action,
    input  wire logic [nfba_pkg::REQ_W-1:0]     i_request_bytes,
    input  wire logic [nfba_pkg::ADDR_W-1:0]    i_block_address,
    output logic                                o_valid,
    output logic      [nfba_pkg::STATUS_W-1:0]  o_status,
    output logic      [nfba_pkg::ADDR_W-1:0]    o_user_address,
    input  wire logic                           i_cfg_we,
    input  wire logic [nfba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [nfba_pkg::END_W-1:0]     i_cfg_wdata
);

    import nfba_pkg::*;

    logic [START_W-1:0] r_heap_start;
    logic [END_W-1:0]   r_heap_end;
    t_result            result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_end   <= HEAP_END_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_HEAP_START: r_heap_start <= i_cfg_wdata[START_W-1:0];
                CFG_HEAP_END:   r_heap_end   <= i_cfg_wdata;
                default:        r_heap_end   <= r_heap_end;
            endcase
        end
    end

    nfba_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .i_heap_start    (r_heap_start),
        .i_heap_end      (r_heap_end),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_result        (result)
    );

    assign o_status       = result.status;
    assign o_user_address = result.user_address;

    // An accepted item either starts work or, for a free before layout,
    // answers at once.
    `NFBA_ASSERT_NEXT(a_start_leaves_idle, i_clk, i_rst_n, start && !busy, busy || o_valid, "accepted item neither started nor answered")
    // Results are only presented once the sequencer is back at rest.
    `NFBA_ASSERT_SAME(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy, "result presented while busy")
    // Only a successful operation may report a non-zero user address.
    `NFBA_ASSERT_SAME(a_addr_on_fail, i_clk, i_rst_n, o_valid && (o_status != ST_DONE), o_user_address == '0, "failed item reports an address")

endmodule

`default_nettype wire

// ===== verif/tb_next_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit block allocator testbench
// Drives allocate and free items through the start/busy handshake and checks
// each result against a behavioural copy of the heap kept in the testbench.
// ----------------------------------------------------------------------------
module tb_next_fit_block_allocator;

    import nfba_pkg::*;

    localparam int HEAP_WORDS = HEAP_WORDS_DEF;
    localparam int LINK_W     = $clog2(HEAP_WORDS);

    typedef logic [LINK_W:0] t_header;  // {next header index, free bit}

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_action;
    logic [REQ_W-1:0]     i_request_bytes;
    logic [ADDR_W-1:0]    i_block_address;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_user_address;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [END_W-1:0]     i_cfg_wdata;

    // Behavioural copy of the heap.
    t_header           header_mem [HEAP_WORDS];
    int unsigned       rover_word;
    int unsigned       end_header_word;
    bit                heap_ready;
    logic [START_W-1:0] heap_start_reg;
    logic [END_W-1:0]   heap_end_reg;

    t_result           pending_replies [$];
    logic [ADDR_W-1:0] live_blocks [$];
    logic [ADDR_W-1:0] freed_blocks [$];
    int                n_errors;
    bit                idle_gaps;

    next_fit_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_user_address  (o_user_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned next_of(int unsigned w);
        return 32'(header_mem[LINK_W'(w % HEAP_WORDS)][LINK_W:1]);
    endfunction

    function automatic bit is_free_word(int unsigned w);
        return header_mem[LINK_W'(w % HEAP_WORDS)][0];
    endfunction

    function automatic void write_header(int unsigned w, int unsigned n, bit f);
        header_mem[LINK_W'(w % HEAP_WORDS)] = {LINK_W'(n % HEAP_WORDS), f};
    endfunction

    // Applies one item to the heap copy and returns the result it must give.
    function automatic t_result predict_heap_op(logic act, logic [REQ_W-1:0] req,
                                                logic [ADDR_W-1:0] uaddr);
        t_result     res;
        int unsigned lo, hi, need, cur, first_cur, t, n, sz, nw, b;
        res.status       = ST_DONE;
        res.user_address = '0;
        if (act == ACT_ALLOC) begin
            if (!heap_ready) begin
                lo = (32'(heap_start_reg) + 7) & ~32'd7;
                hi = 32'(heap_end_reg) & ~32'd7;
                if (hi > HEAP_WORDS * 8)
                    hi = HEAP_WORDS * 8;
                if (lo + 24 > hi) begin
                    res.status = ST_NO_FIT;
                    return res;
                end
                write_header(lo / 8, hi / 8 - 1, 1'b1);
                write_header(hi / 8 - 1, lo / 8, 1'b0);
                rover_word      = lo / 8;
                end_header_word = hi / 8 - 1;
                heap_ready      = 1'b1;
            end
            need       = ((32'(req) + 7) & ~32'd7) / 8;
            cur        = rover_word % HEAP_WORDS;
            first_cur  = cur;
            res.status = ST_NO_FIT;
            for (int steps = 0; steps < HEAP_WORDS; steps++) begin
                if (is_free_word(cur)) begin
                    // Fold the run of free blocks that follows into this one.
                    t = cur;
                    for (int k = 0; k < HEAP_WORDS && is_free_word(t); k++)
                        t = next_of(t);
                    if (t != cur)
                        write_header(cur, t, 1'b1);
                    n = next_of(cur);
                    if (n > cur && n - cur - 1 >= need) begin
                        sz = n - cur - 1;
                        if (sz - need < 2) begin
                            write_header(cur, n, 1'b0);
                        end else begin
                            nw = cur + 1 + need;
                            write_header(nw, n, 1'b1);
                            write_header(cur, nw, 1'b0);
                        end
                        rover_word       = next_of(cur);
                        res.status       = ST_DONE;
                        res.user_address = ADDR_W'((cur + 1) * 8);
                        return res;
                    end
                end
                cur = next_of(cur);
                if (cur == first_cur) begin
                    rover_word = cur;
                    return res;
                end
            end
            rover_word = cur;
        end else begin
            if (!heap_ready) begin
                res.status = ST_NO_FIT;
                return res;
            end
            b = (((32'(uaddr) - 8) & 32'h1FFF) / 8) % HEAP_WORDS;
            if (is_free_word(b)) begin
                res.status = ST_IGNORED;
            end else begin
                n = next_of(b);
                if (is_free_word(n))
                    write_header(b, next_of(n), 1'b1);
                else
                    write_header(b, n, 1'b1);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_result exp;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                $error("result with no item outstanding: status %0d, user_address %0d",
                       o_status, o_user_address);
                n_errors++;
            end else begin
                exp = pending_replies.pop_front();
                if (o_status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, o_status);
                    n_errors++;
                end
                if (o_user_address !== exp.user_address) begin
                    $error("user_address: expected %0d, got %0d",
                           exp.user_address, o_user_address);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [REQ_W-1:0] req,
                             input logic [ADDR_W-1:0] uaddr, output t_result exp);
        if (idle_gaps) begin
            while ($urandom_range(0, 99) < 13) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start           <= 1'b1;
        i_action        <= act;
        i_request_bytes <= req;
        i_block_address <= uaddr;
        do @(posedge i_clk); while (busy);
        exp = predict_heap_op(act, req, uaddr);
        pending_replies.push_back(exp);
    endtask

    task automatic wait_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [END_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_HEAP_START)
            heap_start_reg = START_W'(data);
        else
            heap_end_reg = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Frees before layout and heaps too small to lay out, the end clamp among them.
    task automatic test_before_layout();
        t_result exp;
        send_item(ACT_FREE, '0, '0, exp);
        wait_replies();
        cfg_write(CFG_HEAP_START, 14'd8191);
        cfg_write(CFG_HEAP_END, 14'd0);
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        wait_replies();
        cfg_write(CFG_HEAP_START, 14'd0);
        cfg_write(CFG_HEAP_END, 14'd16);
        send_item(ACT_ALLOC, 14'd0, '0, exp);
        wait_replies();
        // Without the clamp to the table size this heap would fit.
        cfg_write(CFG_HEAP_START, 14'd8180);
        cfg_write(CFG_HEAP_END, 14'd16383);
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        wait_replies();
        cfg_write(CFG_HEAP_START, 14'd8);
        cfg_write(CFG_HEAP_END, 14'd31);
        send_item(ACT_ALLOC, 14'd0, '0, exp);
        send_item(ACT_FREE, '0, 13'd8191, exp);
        wait_replies();
    endtask

    // Layout, splits, whole takes, exact fit, full heap and odd addresses.
    task automatic test_layout_corners();
        t_result           exp;
        logic [ADDR_W-1:0] a0, a1, a2, a_rem;
        int unsigned       rem;
        cfg_write(CFG_HEAP_START, 14'd6001);
        cfg_write(CFG_HEAP_END, 14'd8005);
        send_item(ACT_ALLOC, 14'd0, '0, exp);
        a0 = exp.user_address;
        send_item(ACT_ALLOC, 14'd1, '0, exp);
        a1 = exp.user_address;
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        a2 = exp.user_address;
        send_item(ACT_ALLOC, 14'd8192, '0, exp);
        send_item(ACT_ALLOC, 14'd16383, '0, exp);
        send_item(ACT_FREE, '0, a1, exp);
        send_item(ACT_FREE, '0, a1, exp);
        send_item(ACT_FREE, '0, a0 + 13'd5, exp);
        // Address zero wraps to the top word of the table.
        send_item(ACT_FREE, '0, 13'd0, exp);
        send_item(ACT_FREE, '0, 13'd0, exp);
        send_item(ACT_FREE, '0, 13'd8191, exp);
        // Leave one spare word, too few to split off.
        rem = next_of(rover_word) - rover_word - 1;
        send_item(ACT_ALLOC, REQ_W'((rem - 1) * 8 - 7), '0, exp);
        a_rem = exp.user_address;
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        send_item(ACT_FREE, '0, a2, exp);
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        wait_replies();
        live_blocks.push_back(a_rem);
    endtask

    // Register writes once the heap is laid out must leave the layout alone.
    task automatic test_registers_after_layout();
        t_result exp;
        cfg_write(CFG_HEAP_START, 14'd0);
        cfg_write(CFG_HEAP_END, 14'd8192);
        send_item(ACT_FREE, '0, live_blocks.pop_front(), exp);
        send_item(ACT_ALLOC, 14'd16, '0, exp);
        if (exp.status == ST_DONE)
            live_blocks.push_back(exp.user_address);
        wait_replies();
    endtask

    task automatic test_random_traffic(input int n_items);
        t_result           exp;
        int unsigned       r, pick, w;
        logic [ADDR_W-1:0] uaddr;
        logic [REQ_W-1:0]  req;
        for (int i = 0; i < n_items; i++) begin
            idle_gaps = (i < 400) || (i >= 700);
            r     = $urandom_range(0, 99);
            req   = REQ_W'($urandom_range(0, 16383));
            uaddr = ADDR_W'($urandom_range(0, 8191));
            if (r < 8) begin
                // Stray free anywhere except on the end header.
                w = ((32'(uaddr) - 8) & 32'h1FFF) / 8;
                while (w == end_header_word) begin
                    uaddr = ADDR_W'($urandom_range(0, 8191));
                    w     = ((32'(uaddr) - 8) & 32'h1FFF) / 8;
                end
                send_item(ACT_FREE, req, uaddr, exp);
            end else if (r < 12) begin
                send_item(ACT_ALLOC, req, uaddr, exp);
            end else if (r < 16 && freed_blocks.size() != 0) begin
                pick = $urandom_range(0, freed_blocks.size() - 1);
                send_item(ACT_FREE, req, freed_blocks[pick], exp);
            end else if (live_blocks.size() == 0 || r < 58) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    req = REQ_W'($urandom_range(0, 64));
                else if (pick < 95)
                    req = REQ_W'($urandom_range(65, 400));
                else
                    req = REQ_W'($urandom_range(401, 2100));
                send_item(ACT_ALLOC, req, uaddr, exp);
                if (exp.status == ST_DONE)
                    live_blocks.push_back(exp.user_address);
            end else begin
                pick  = $urandom_range(0, live_blocks.size() - 1);
                uaddr = live_blocks[pick];
                live_blocks.delete(pick);
                freed_blocks.push_back(uaddr);
                if (freed_blocks.size() > 16)
                    void'(freed_blocks.pop_front());
                send_item(ACT_FREE, req, uaddr + ADDR_W'($urandom_range(0, 7)), exp);
            end
        end
        idle_gaps = 1'b1;
        wait_replies();
    endtask

    // Freeing the end header leaves a free block that links backwards.
    task automatic test_end_header_release();
        t_result exp;
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        send_item(ACT_FREE, '0, ADDR_W'((end_header_word + 1) * 8), exp);
        send_item(ACT_ALLOC, 14'd8, '0, exp);
        send_item(ACT_ALLOC, 14'd64, '0, exp);
        send_item(ACT_ALLOC, 14'd0, '0, exp);
        wait_replies();
    endtask

    initial begin
        foreach (header_mem[i])
            header_mem[i] = '0;
        rover_word      = 0;
        end_header_word = 0;
        heap_ready      = 1'b0;
        heap_start_reg  = '0;
        heap_end_reg    = HEAP_END_RST;
        n_errors        = 0;
        idle_gaps       = 1'b1;

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_action        <= ACT_ALLOC;
        i_request_bytes <= '0;
        i_block_address <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_HEAP_START;
        i_cfg_wdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_layout();
        test_layout_corners();
        test_registers_after_layout();
        test_random_traffic(1300);
        test_end_header_release();

        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
